>>> rtl/core/b64w_pkg.sv
package b64w_pkg;

	// ascii codes used on the character stream
	localparam logic [7:0] ChrCr  = 8'h0D;
	localparam logic [7:0] ChrLf  = 8'h0A;
	localparam logic [7:0] ChrPad = 8'h3D;

	localparam logic [15:0] LineLimitRst = 16'd76;
	localparam logic [16:0] GrpChars     = 17'd4;

	// group queue between front and back
	localparam int GrpDepth = 2;
	localparam int GrpPtrW  = $clog2(GrpDepth);
	localparam int GrpCntW  = GrpPtrW + 1;

	// character positions inside one emitted group
	localparam logic [2:0] PosCr = 3'd0;
	localparam logic [2:0] PosLf = 3'd1;
	localparam logic [2:0] PosS0 = 3'd2;
	localparam logic [2:0] PosS3 = 3'd5;

	// slots of the four output characters
	localparam logic [1:0] SlotS0 = 2'd0;
	localparam logic [1:0] SlotS1 = 2'd1;
	localparam logic [1:0] SlotS2 = 2'd2;
	localparam logic [1:0] SlotS3 = 2'd3;

	typedef enum logic [1:0] {
		PadNone = 2'd0,
		PadOne  = 2'd1,
		PadTwo  = 2'd2
	} b64w_pad_t;

	// one group of up to three bytes, ready for character generation
	typedef struct packed {
		logic [7:0] byte_a;
		logic [7:0] byte_c;
		logic [7:0] byte_b;
		b64w_pad_t  pad;
		logic       brk;
		logic       last;
	} b64w_grp_t;

	// standard alphabet lookup
	function automatic logic [7:0] b64w_sym(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return w + 8'd65;
		else if (v < 6'd52)
			return w + 8'd71;
		else if (v < 6'd62)
			return w - 8'd4;
		else if (v == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

endpackage

>>> rtl/core/b64w_if.sv
interface b64w_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_data;

	modport source(output valid, output in_byte, output end_of_data, input ready);
	modport sink(input valid, input in_byte, input end_of_data, output ready);
endinterface

interface b64w_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source(output valid, output out_char, output last_char, input ready);
	modport sink(input valid, input out_char, input last_char, output ready);
endinterface

>>> rtl/core/base64_line_wrapping_encoder_top.sv
// base64 encoder with crlf line wrapping
//
// msg channel: one message byte per transfer, end_of_data set on the
// final byte of a message. enc channel: one ascii character per transfer,
// last_char set on the final character of the message.
// line_limit_we / line_limit_wdata write the line limit (reset 76); write
// it only while no message is in flight.
// every third byte, or the final byte, yields a group of four characters,
// preceded by cr lf when line length + 4 reaches the limit.
// the byte that completes a group writes it into the queue, and its first
// character is loaded from the queue head into the output register.
// one character per cycle while a group is queued and enc is ready, set
// by the single output register; at most six characters per three bytes,
// with bursts of bytes taken back to back through the two-entry queue.
// reset clears pending bytes, line length, the queue and the output.
// when enc stalls, the output holds, the queue fills, then msg ready drops.
module base64_line_wrapping_encoder_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         line_limit_we,
	input  logic [15:0]  line_limit_wdata,
	b64w_byte_if.sink    msg,
	b64w_char_if.source  enc
);

	// front to queue
	logic                 grp_push;
	b64w_pkg::b64w_grp_t  grp_data;
	logic                 grp_full;

	// queue to back
	logic                 head_valid;
	b64w_pkg::b64w_grp_t  head;
	logic                 grp_pop;

	// front: byte collection, line length and break decision
	b64w_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_limit_we    (line_limit_we),
		.line_limit_wdata (line_limit_wdata),
		.msg              (msg),
		.grp_full         (grp_full),
		.grp_push         (grp_push),
		.grp_data         (grp_data)
	);

	// short queue of decided groups
	b64w_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (grp_push),
		.push_data  (grp_data),
		.full       (grp_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (grp_pop)
	);

	// back: one character per cycle into the output register, while enc is ready
	b64w_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (grp_pop),
		.enc        (enc)
	);

endmodule

>>> rtl/core/b64w_front.sv
module b64w_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  line_limit_we,
	input  logic [15:0]           line_limit_wdata,
	b64w_byte_if.sink             msg,
	input  logic                  grp_full,
	output logic                  grp_push,
	output b64w_pkg::b64w_grp_t   grp_data
);

	logic [15:0] line_limit_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [1:0]  pend_cnt_q;
	logic [15:0] line_len_q;

	logic        accept;
	logic        full_grp;
	logic        brk;

	assign msg.ready = !grp_full;
	assign accept    = msg.valid && msg.ready;
	assign full_grp  = pend_cnt_q[1];
	assign brk       = ({1'b0, line_len_q} + b64w_pkg::GrpChars) >= {1'b0, line_limit_q};
	assign grp_push  = accept && (full_grp || msg.end_of_data);

	// group contents; short groups carry zero fill
	always_comb begin
		grp_data      = '0;
		grp_data.brk  = brk;
		grp_data.last = msg.end_of_data;
		if (full_grp) begin
			grp_data.byte_a = first_q;
			grp_data.byte_c = second_q;
			grp_data.byte_b = msg.in_byte;
			grp_data.pad    = b64w_pkg::PadNone;
		end else if (pend_cnt_q == 2'd1) begin
			grp_data.byte_a = first_q;
			grp_data.byte_c = msg.in_byte;
			grp_data.pad    = b64w_pkg::PadOne;
		end else begin
			grp_data.byte_a = msg.in_byte;
			grp_data.pad    = b64w_pkg::PadTwo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= b64w_pkg::LineLimitRst;
		end else if (line_limit_we) begin
			line_limit_q <= line_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= '0;
			second_q   <= '0;
			pend_cnt_q <= '0;
			line_len_q <= '0;
		end else if (accept) begin
			if (msg.end_of_data) begin
				first_q    <= '0;
				second_q   <= '0;
				pend_cnt_q <= '0;
				line_len_q <= '0;
			end else if (full_grp) begin
				pend_cnt_q <= '0;
				line_len_q <= (brk ? 16'd0 : line_len_q) + 16'(b64w_pkg::GrpChars);
			end else if (pend_cnt_q == 2'd1) begin
				second_q   <= msg.in_byte;
				pend_cnt_q <= 2'd2;
			end else begin
				first_q    <= msg.in_byte;
				pend_cnt_q <= 2'd1;
			end
		end
	end

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("pending byte count out of range");

	a_msg_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && msg.end_of_data |=> pend_cnt_q == 2'd0 && line_len_q == 16'd0)
		else $error("group state not cleared after message end");

	a_len_whole_groups: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q[1:0] == 2'b00)
		else $error("line length not a whole number of groups");

endmodule

>>> rtl/core/b64w_fifo.sv
module b64w_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64w_pkg::b64w_grp_t   push_data,
	output logic                  full,
	output logic                  head_valid,
	output b64w_pkg::b64w_grp_t   head,
	input  logic                  pop
);

	b64w_pkg::b64w_grp_t                mem_q [b64w_pkg::GrpDepth];
	logic [b64w_pkg::GrpPtrW-1:0]       wr_ptr_q;
	logic [b64w_pkg::GrpPtrW-1:0]       rd_ptr_q;
	logic [b64w_pkg::GrpCntW-1:0]       count_q;

	assign full       = count_q == b64w_pkg::GrpCntW'(b64w_pkg::GrpDepth);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [b64w_pkg::GrpPtrW-1:0] next_ptr(
		input logic [b64w_pkg::GrpPtrW-1:0] p);
		if (p == b64w_pkg::GrpPtrW'(b64w_pkg::GrpDepth - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full || pop) and (pop |-> head_valid))
		else $error("group queue overrun or underrun");

endmodule

>>> rtl/core/b64w_back.sv
module b64w_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  b64w_pkg::b64w_grp_t   head,
	output logic                  pop,
	b64w_char_if.source           enc
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	logic [2:0] cur_pos;
	logic [1:0] slot;
	logic [5:0] sextet;
	logic       is_pad;
	logic [7:0] chr;
	logic       load;

	assign load = head_valid && (!out_valid_q || enc.ready);
	assign pop  = load && (cur_pos == b64w_pkg::PosS3);

	assign enc.valid     = out_valid_q;
	assign enc.out_char  = out_char_q;
	assign enc.last_char = out_last_q;

	always_comb begin
		cur_pos = idx_q;
		if (!head.brk && idx_q == b64w_pkg::PosCr) begin
			cur_pos = b64w_pkg::PosS0;
		end
		slot = 2'(cur_pos - b64w_pkg::PosS0);
		case (slot)
			b64w_pkg::SlotS0: sextet = head.byte_a[7:2];
			b64w_pkg::SlotS1: sextet = {head.byte_a[1:0], head.byte_c[7:4]};
			b64w_pkg::SlotS2: sextet = {head.byte_c[3:0], head.byte_b[7:6]};
			default:          sextet = head.byte_b[5:0];
		endcase
		is_pad = (head.pad == b64w_pkg::PadTwo &&
		          (slot == b64w_pkg::SlotS2 || slot == b64w_pkg::SlotS3)) ||
		         (head.pad == b64w_pkg::PadOne && slot == b64w_pkg::SlotS3);
		if (cur_pos == b64w_pkg::PosCr)
			chr = b64w_pkg::ChrCr;
		else if (cur_pos == b64w_pkg::PosLf)
			chr = b64w_pkg::ChrLf;
		else if (is_pad)
			chr = b64w_pkg::ChrPad;
		else
			chr = b64w_pkg::b64w_sym(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= b64w_pkg::PosCr;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= pop ? b64w_pkg::PosCr : cur_pos + 3'd1;
				out_valid_q <= 1'b1;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= chr;
			out_last_q <= head.last && cur_pos == b64w_pkg::PosS3;
		end
	end

	a_group_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == b64w_pkg::PosCr && out_valid_q)
		else $error("group did not end on its fourth character");

endmodule

>>> tb/b64w_encode_checker.sv
`timescale 1ns / 1ps

module b64w_encode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        limit_we,
	input  logic [15:0] limit_wdata,
	input  logic        msg_valid,
	input  logic        msg_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_data,
	input  logic        enc_valid,
	input  logic        enc_ready,
	input  logic [7:0]  out_char,
	input  logic        last_char,
	output int          fail_count,
	output int          chars_owed
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	enc_char_t   encoded_q[$];
	logic [15:0] limit_reg;
	logic [7:0]  held_a;
	logic [7:0]  held_c;
	logic [1:0]  held_cnt;
	logic [15:0] line_len;
	int          errors;

	function automatic logic [7:0] b64_digit(input logic [5:0] v);
		string digits;
		digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		return digits[v];
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic last);
		enc_char_t e;
		e.ch = ch;
		e.last = last;
		encoded_q.push_back(e);
	endtask

	// cr lf ahead of a group once the line would reach the limit
	task automatic line_break();
		if ({16'd0, line_len} + 32'd4 >= {16'd0, limit_reg}) begin
			push_char(b64w_pkg::ChrCr, 1'b0);
			push_char(b64w_pkg::ChrLf, 1'b0);
			line_len = '0;
		end
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic eod);
		logic [7:0] a;
		logic [7:0] c;
		if (held_cnt == 2'd2) begin
			a = held_a;
			c = held_c;
			line_break();
			push_char(b64_digit(a[7:2]), 1'b0);
			push_char(b64_digit({a[1:0], c[7:4]}), 1'b0);
			push_char(b64_digit({c[3:0], b[7:6]}), 1'b0);
			push_char(b64_digit(b[5:0]), eod);
			line_len = line_len + 16'd4;
			held_cnt = 2'd0;
		end else if (eod) begin
			a = (held_cnt == 2'd1) ? held_a : b;
			c = b;
			line_break();
			push_char(b64_digit(a[7:2]), 1'b0);
			if (held_cnt == 2'd1) begin
				push_char(b64_digit({a[1:0], c[7:4]}), 1'b0);
				push_char(b64_digit({c[3:0], 2'b00}), 1'b0);
				push_char(b64w_pkg::ChrPad, 1'b1);
			end else begin
				push_char(b64_digit({a[1:0], 4'b0000}), 1'b0);
				push_char(b64w_pkg::ChrPad, 1'b0);
				push_char(b64w_pkg::ChrPad, 1'b1);
			end
		end else if (held_cnt == 2'd1) begin
			held_c = b;
			held_cnt = 2'd2;
		end else begin
			held_a = b;
			held_cnt = 2'd1;
		end
		// message end clears group and line state
		if (eod) begin
			held_a = '0;
			held_c = '0;
			held_cnt = '0;
			line_len = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		enc_char_t exp_char;
		if (!arst_n) begin
			encoded_q.delete();
			limit_reg = b64w_pkg::LineLimitRst;
			held_a = '0;
			held_c = '0;
			held_cnt = '0;
			line_len = '0;
			errors = 0;
			fail_count <= 0;
			chars_owed <= 0;
		end else begin
			if (enc_valid && enc_ready) begin
				if (encoded_q.size() == 0) begin
					$display("%0t: unexpected char: expected none, actual %h last %b",
						$time, out_char, last_char);
					errors++;
				end else begin
					exp_char = encoded_q.pop_front();
					if (out_char !== exp_char.ch) begin
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, exp_char.ch, out_char);
						errors++;
					end
					if (last_char !== exp_char.last) begin
						$display("%0t: last_char mismatch: expected %b, actual %b",
							$time, exp_char.last, last_char);
						errors++;
					end
				end
			end
			if (msg_valid && msg_ready)
				encode_byte(in_byte, end_of_data);
			if (limit_we)
				limit_reg = limit_wdata;
			fail_count <= errors;
			chars_owed <= encoded_q.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	// cycles without any transfer before the run is declared hung
	localparam int WatchdogLimit = 2000;
	// quiet cycles before a limit write, past the queue and output stages
	localparam int SettleCycles  = 8;
	localparam int NumPhases     = 10;
	localparam int PhaseBytes    = 44;

	logic        clk;
	logic        arst_n;
	logic        limit_we;
	logic [15:0] limit_wdata;
	int          fail_count;
	int          chars_owed;
	int          stall_cycles = 0;
	bit          gaps_on;

	b64w_byte_if msg_if ();
	b64w_char_if enc_if ();

	base64_line_wrapping_encoder_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_limit_we    (limit_we),
		.line_limit_wdata (limit_wdata),
		.msg              (msg_if),
		.enc              (enc_if)
	);

	b64w_encode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.msg_valid   (msg_if.valid),
		.msg_ready   (msg_if.ready),
		.in_byte     (msg_if.in_byte),
		.end_of_data (msg_if.end_of_data),
		.enc_valid   (enc_if.valid),
		.enc_ready   (enc_if.ready),
		.out_char    (enc_if.out_char),
		.last_char   (enc_if.last_char),
		.fail_count  (fail_count),
		.chars_owed  (chars_owed)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hang detection: any transfer on either channel resets the count
	always @(posedge clk) begin
		if ((msg_if.valid && msg_if.ready) || (enc_if.valid && enc_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WatchdogLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// character sink: ready drops in random bursts while gaps are enabled
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				enc_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			enc_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// one byte transfer, optionally after a random gap with valid low;
	// back-to-back bytes keep valid high with a single assignment
	task automatic send_byte(input logic [7:0] b, input logic eod);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			msg_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		msg_if.valid       <= 1'b1;
		msg_if.in_byte     <= b;
		msg_if.end_of_data <= eod;
		@(posedge clk);
		while (!msg_if.ready) @(posedge clk);
	endtask

	// short fixed message, first byte in the low bits, last byte flagged
	task automatic send_fixed(input logic [63:0] bytes, input int n);
		for (int i = 0; i < n; i++)
			send_byte(bytes[8*i +: 8], i == n - 1);
	endtask

	// hold the sender until every predicted character has come out
	task automatic drain();
		msg_if.valid <= 1'b0;
		@(posedge clk);
		while (chars_owed != 0) @(posedge clk);
	endtask

	// limit writes only with the encoder idle
	task automatic write_limit(input logic [15:0] v);
		drain();
		repeat (SettleCycles) @(posedge clk);
		limit_we    <= 1'b1;
		limit_wdata <= v;
		@(posedge clk);
		limit_we    <= 1'b0;
	endtask

	initial begin
		logic [15:0] phase_limit [NumPhases];
		int          len;
		int          sent;
		int          pause_at;

		arst_n             = 1'b0;
		limit_we           = 1'b0;
		limit_wdata        = '0;
		msg_if.valid       = 1'b0;
		msg_if.in_byte     = '0;
		msg_if.end_of_data = 1'b0;
		enc_if.ready       = 1'b0;
		gaps_on            = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset limit: one-byte groups of all zeros and
		// all ones, the two-byte short group, a full group followed by a short one
		send_fixed(64'h00, 1);
		send_fixed(64'hFF, 1);
		send_fixed(64'h00_FF, 2);
		send_fixed(64'h00_FF_FF_FF, 4);

		// zero limit: break before every group, even the only one
		write_limit(16'd0);
		send_fixed(64'h80_7F_01, 3);

		// limit of four still breaks ahead of the first group
		write_limit(16'd4);
		send_fixed(64'h55_AA, 2);

		// limit eight: no break on the first group, then one per group
		write_limit(16'd8);
		send_fixed(64'h3C_C3_0F_F0_01_FE_80, 7);

		// widest limit
		write_limit(16'hFFFF);
		send_fixed(64'h5A_A5_FF, 3);

		// random part: each phase has its own limit, mixed message lengths
		// with an occasional long one, cut to what is left of the phase
		phase_limit = '{16'd76, 16'd1, 16'd5, 16'd12, 16'd3, 16'd20, 16'hFFFF,
			16'd9, 16'd0, 16'd76};
		phase_limit[7] = 16'($urandom_range(5, 100));
		for (int p = 0; p < NumPhases; p++) begin
			write_limit(phase_limit[p]);
			// random gaps off in phase four mid-run and in the last two phases
			gaps_on  = !(p == 4 || p >= NumPhases - 2);
			sent     = 0;
			pause_at = $urandom_range(1, PhaseBytes - 4);
			while (sent < PhaseBytes) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
					: $urandom_range(1, 10);
				// last message of a phase is cut to the phase length
				if (len > PhaseBytes - sent)
					len = PhaseBytes - sent;
				for (int i = 0; i < len; i++) begin
					sent++;
					// sender holds until the output has caught up,
					// possibly with bytes still pending in a group
					if (sent == pause_at)
						drain();
					send_byte(8'($urandom_range(0, 255)), i == len - 1);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && chars_owed == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
